// File: src/alid_pkg.sv
// ----------------------------------------------------------------------------
// alid_pkg: shared definitions for the array list core
// Operation and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package alid_pkg;

	// Default sizes of the list storage.
	localparam int unsigned DEPTH_DEF      = 32;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// Fixed field widths of the request and result transfers.
	localparam int unsigned OP_W     = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned IDX_W    = 5;
	localparam int unsigned CNT_W    = 6;

	// Request operation codes.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BADPOS   = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_DEL,
		S_FIND,
		S_DONE
	} state_t;

endpackage

// File: src/alid_ram.sv
// ----------------------------------------------------------------------------
// alid_ram: list storage
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module alid_ram
	import alid_pkg::*;
#(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [DATA_WIDTH-1:0]      wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [DATA_WIDTH-1:0]      rdata
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/array_list_insert_delete_find_core.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete_find_core: ordered list with insert, delete, find
// A sequencer walks the list storage one entry per cycle to shift entries
// for insert and delete, or to compare them against the key for find.
// ----------------------------------------------------------------------------
// Requests are handled one at a time: a new request is taken only when the
// sequencer is idle, after the last result has been loaded for output.
// Reset: arst_n clears the count (list empty) and the control state; the
// storage words are not cleared, since only written entries are ever read.
module array_list_insert_delete_find_core
	import alid_pkg::*;
#(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op [1:0], value [33:2], position [39:34]
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status [1:0], found_index [6:2], entry_count [12:7], zero [15:13]
	output logic [15:0] m_axis_tdata
);

	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int unsigned VW   = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

	// Request fields.
	logic [OP_W-1:0]    in_op;
	logic [VALUE_W-1:0] in_value;
	logic [POS_W-1:0]   in_pos;
	logic [CMPW-1:0]    pos_ext;
	logic [CMPW-1:0]    cnt_ext;
	logic               accept;

	assign in_op    = s_axis_tdata[1:0];
	assign in_value = s_axis_tdata[33:2];
	assign in_pos   = s_axis_tdata[39:34];

	// Control and data registers.
	state_t                state_q, state_d;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         moves_q;
	logic [AW-1:0]         rd_ptr_q;
	logic [AW-1:0]         ins_addr_q;
	logic [DATA_WIDTH-1:0] val_q;
	status_t               res_status_q;
	logic [IDX_W-1:0]      res_idx_q;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_addr_s1;
	logic                  m_valid_q;
	logic [15:0]           m_data_q;

	// Decoded request.
	state_t        dec_state;
	status_t       dec_status;
	logic [CW-1:0] dec_moves;
	logic [AW-1:0] dec_ptr;

	// Walk control.
	logic                  walk_done;
	logic                  issue;
	logic                  hit;
	logic                  out_load;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pos_ext       = CMPW'(in_pos);
	assign cnt_ext       = CMPW'(count_q);

	// Request checks and walk setup.
	always_comb begin
		dec_state  = S_DONE;
		dec_status = ST_OK;
		dec_moves  = '0;
		dec_ptr    = '0;
		unique case (in_op)
			OP_INSERT: begin
				if (count_q >= CW'(DEPTH)) begin
					dec_status = ST_FULL;
				end else if (in_pos == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_state = S_INS;
					dec_moves = CW'(cnt_ext - pos_ext + CMPW'(1));
					dec_ptr   = AW'(cnt_ext - CMPW'(1));
				end
			end
			OP_DELETE: begin
				if (in_pos == '0 || pos_ext > cnt_ext) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_state = S_DEL;
					dec_moves = CW'(cnt_ext - pos_ext);
					dec_ptr   = AW'(pos_ext);
				end
			end
			OP_FIND: begin
				dec_state  = S_FIND;
				dec_status = ST_NOTFOUND;
				dec_moves  = count_q;
			end
			default: begin
				dec_status = ST_BADPOS;
			end
		endcase
	end

	assign walk_done = (moves_q == '0) && !rd_vld_s1;
	assign hit       = (state_q == S_FIND) && rd_vld_s1 && (ram_rdata == val_q);
	assign out_load  = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = dec_state;
				end
			end
			S_INS, S_DEL: begin
				if (walk_done) begin
					state_d = S_DONE;
				end
			end
			S_FIND: begin
				if (hit || walk_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Storage access for each state.
	always_comb begin
		issue     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_INS: begin
				issue = (moves_q != '0);
				if (rd_vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = rd_addr_s1 + AW'(1);
				end else if (moves_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = ins_addr_q;
					ram_wdata = val_q;
				end
			end
			S_DEL: begin
				issue = (moves_q != '0);
				if (rd_vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = rd_addr_s1 - AW'(1);
				end
			end
			S_FIND: begin
				issue = (moves_q != '0) && !hit;
			end
			S_IDLE, S_DONE: begin
				issue = 1'b0;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	alid_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// Sequencer state, count and walk counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			moves_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (accept) begin
				moves_q <= dec_moves;
			end else if (issue) begin
				moves_q <= moves_q - CW'(1);
			end
			if (state_q == S_INS && walk_done) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_DEL && walk_done) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Read pointer, request payload and result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ptr_q     <= dec_ptr;
			ins_addr_q   <= AW'(pos_ext - CMPW'(1));
			val_q        <= DATA_WIDTH'(in_value[VW-1:0]);
			res_status_q <= dec_status;
			res_idx_q    <= '0;
		end else if (issue) begin
			if (state_q == S_INS) begin
				rd_ptr_q <= rd_ptr_q - AW'(1);
			end else begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
		end
		if (issue) begin
			rd_addr_s1 <= rd_ptr_q;
		end
		if (hit) begin
			res_status_q <= ST_OK;
			res_idx_q    <= IDX_W'(rd_addr_s1);
		end
	end

	// Result output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {3'b000, CNT_W'(count_q), res_idx_q, res_status_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// File: tb/sv/tb_array_list_insert_delete_find_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_list_insert_delete_find_core: regression for the array list core
// Requests (insert, delete, find and the unused op code) are queued up front
// and driven on the request stream. Every accepted request runs through a
// local list model, and each result transfer is checked field by field
// against the oldest predicted result. Both stream sides idle at random, but not in the last phase.
// ----------------------------------------------------------------------------
module tb_array_list_insert_delete_find_core;
	import alid_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned LIST_MAX = DEPTH_DEF;
	localparam int RANDOM_REQS = 830;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 50;
	localparam int HOLD_CYCLES = 300;

	// One request as packed on the request stream.
	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] value;
		logic [OP_W-1:0]    op;
	} list_req_t;

	// One result as packed on the result stream, without the zero pad.
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [IDX_W-1:0] idx;
		status_t          status;
	} list_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	// List model state.
	logic [VALUE_W-1:0] list_words [LIST_MAX];
	int                 list_len = 0;

	// Stimulus and scoreboard storage.
	list_req_t pending_reqs [$];
	list_res_t due_results [$];
	list_req_t due_reqs [$];
	int        gen_len = 0;
	bit        growing = 1'b1;
	int        req_total = 0;
	int        req_done = 0;
	int        res_done = 0;
	int        fail_count = 0;
	int        op_seen [4];
	int        status_seen [4];
	int        full_hits = 0;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	int        quiet_cycles = 0;

	array_list_insert_delete_find_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Apply one request to the list model and return the result it gives.
	function automatic list_res_t list_apply(list_req_t req);
		list_res_t r;
		int p;
		int i;
		bit hit;
		p = int'(req.pos);
		hit = 1'b0;
		r.status = ST_OK;
		r.idx = '0;
		case (req.op)
			OP_INSERT: begin
				if (list_len >= LIST_MAX) begin
					r.status = ST_FULL;
				end else if (p < 1 || p > list_len + 1) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = list_len; i >= p; i--)
						list_words[i] = list_words[i - 1];
					list_words[p - 1] = req.value;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (p < 1 || p > list_len) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = p - 1; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
			OP_FIND: begin
				// The lowest matching index wins.
				for (i = 0; i < list_len; i++) begin
					if (!hit && list_words[i] == req.value) begin
						hit = 1'b1;
						r.idx = i[IDX_W-1:0];
					end
				end
				if (!hit)
					r.status = ST_NOTFOUND;
			end
			default: r.status = ST_BADPOS;
		endcase
		r.cnt = list_len[CNT_W-1:0];
		return r;
	endfunction

	// Queue a request and track the list length it leaves behind.
	task automatic add_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value, int pos);
		list_req_t req;
		req.op = op;
		req.value = value;
		req.pos = pos[POS_W-1:0];
		pending_reqs.push_back(req);
		if (op == OP_INSERT && gen_len < LIST_MAX && pos >= 1 && pos <= gen_len + 1)
			gen_len++;
		else if (op == OP_DELETE && pos >= 1 && pos <= gen_len)
			gen_len--;
	endtask

	// Values mostly come from a small pool so that finds hit and duplicates occur.
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] pool [8];
		pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_0005, 32'h0000_0014, 32'hFFFF_FFEC};
		if ($urandom_range(0, 99) < 60)
			return pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// Random request: the list swings between filling up and draining.
	task automatic add_random_request();
		int roll;
		bit ins;
		roll = $urandom_range(0, 99);
		if (growing && gen_len == LIST_MAX && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		else if (!growing && gen_len == 0 && $urandom_range(0, 3) == 0)
			growing = 1'b1;
		ins = growing ? (roll < 80) : (roll >= 80);
		if (roll < 3) begin
			add_request(OP_UNUSED, $urandom, $urandom_range(0, 63));
		end else if (roll < 6) begin
			// Position beyond the legal range, or zero.
			if ($urandom_range(0, 1))
				add_request(OP_INSERT, pick_value(),
					$urandom_range(0, 1) ? 0 : $urandom_range(gen_len + 2, 63));
			else
				add_request(OP_DELETE, pick_value(),
					$urandom_range(0, 1) ? 0 : $urandom_range(gen_len + 1, 63));
		end else if (roll < 30) begin
			add_request(OP_FIND, pick_value(), $urandom_range(0, 63));
		end else if (ins) begin
			add_request(OP_INSERT, pick_value(), $urandom_range(1, gen_len + 1));
		end else if (gen_len > 0) begin
			add_request(OP_DELETE, pick_value(), $urandom_range(1, gen_len));
		end else begin
			add_request(OP_DELETE, pick_value(), $urandom_range(0, 63));
		end
	endtask

	// Idle rates per phase of the run.
	always_comb begin
		if (req_done < req_total / 3) begin
			send_idle_pct = 7;
			recv_stall_pct = 75;
		end else if (req_done < 2 * req_total / 3) begin
			send_idle_pct = 75;
			recv_stall_pct = 7;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
	end

	// Request driver: offer the next pending request once the last one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_reqs.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off in the last phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (!hold_done && req_done >= 2 * req_total / 3 + 20) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= (hold_left == 1);
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: check each result transfer, then predict for each request transfer.
	always @(posedge clk) begin
		list_res_t got;
		list_res_t want;
		list_req_t req;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[12:0];
				res_done++;
				if (due_results.size() == 0) begin
					$display("%0t: result with none pending: actual %h", $time, got);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					req = due_reqs.pop_front();
					op_seen[req.op]++;
					status_seen[want.status]++;
					if (got.status != want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, got.status);
						fail_count++;
					end
					if (got.idx != want.idx) begin
						$display("%0t: found_index mismatch: expected %0d, actual %0d",
							$time, want.idx, got.idx);
						fail_count++;
					end
					if (got.cnt != want.cnt) begin
						$display("%0t: entry_count mismatch: expected %0d, actual %0d",
							$time, want.cnt, got.cnt);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req = s_axis_tdata;
				req_done++;
				due_reqs.push_back(req);
				due_results.push_back(list_apply(req));
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("array_list_insert_delete_find_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		// Directed requests: empty list, bad positions, unused op, list edges.
		add_request(OP_FIND, 32'h0000_0000, 0);
		add_request(OP_DELETE, 32'h0000_0000, 1);
		add_request(OP_INSERT, 32'h0000_0001, 0);
		add_request(OP_INSERT, 32'h0000_0001, 2);
		add_request(OP_UNUSED, 32'hFFFF_FFFF, 63);
		add_request(OP_INSERT, 32'h8000_0000, 1);
		add_request(OP_INSERT, 32'h7FFF_FFFF, 2);
		add_request(OP_INSERT, 32'hFFFF_FFFF, 1);
		add_request(OP_INSERT, 32'h0000_0000, 2);
		add_request(OP_INSERT, 32'h7FFF_FFFF, 5);
		add_request(OP_FIND, 32'h7FFF_FFFF, 63);
		add_request(OP_FIND, 32'h0000_0000, 0);
		add_request(OP_FIND, 32'hFFFF_FFFF, 0);
		add_request(OP_FIND, 32'h0000_3039, 0);
		add_request(OP_DELETE, 32'h0000_0000, 6);
		add_request(OP_DELETE, 32'h0000_0000, 63);
		add_request(OP_INSERT, 32'h0000_0000, 63);
		add_request(OP_DELETE, 32'h0000_0000, 1);
		add_request(OP_DELETE, 32'h0000_0000, 4);
		add_request(OP_DELETE, 32'h0000_0000, 2);
		add_request(OP_FIND, 32'h8000_0000, 0);
		add_request(OP_UNUSED, 32'h0000_0000, 0);
		repeat (RANDOM_REQS)
			add_random_request();
		req_total = pending_reqs.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all requests taken, all results back, then a quiet tail.
		while (req_done < req_total || due_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests: %0d insert, %0d delete, %0d find, %0d unused op.",
			req_done, op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_FIND],
			op_seen[OP_UNUSED]);
		$display("Results: %0d ok, %0d full, %0d bad position, %0d not found.",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
			status_seen[ST_NOTFOUND]);
		if (fail_count == 0 && due_results.size() == 0)
			$display("array_list_insert_delete_find_core regression: pass");
		else
			$display("array_list_insert_delete_find_core regression: fail");
		$finish;
	end

endmodule
